FILE: hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // One hue sector is 60 degrees in Q9.6, i.e. 3840 raw counts
  localparam int unsigned HueSector = 3840;
  // Common denominator of all factors: 1024 * 3840
  localparam int unsigned FracDen   = 1024 * HueSector;
  localparam int unsigned ChanMax   = 255;
  // Sectors above hue 300 degrees fold into the last case
  localparam int unsigned NumSector = 9;

  localparam int unsigned HueW  = 15;
  localparam int unsigned SatW  = 12;
  localparam int unsigned ValW  = 12;
  localparam int unsigned SecW  = 4;
  localparam int unsigned RemW  = 12;
  localparam int unsigned MagW  = 22;
  localparam int unsigned VsW   = 20;
  localparam int unsigned HiW   = 14;
  localparam int unsigned ByteW = 8;

  // Sector codes, floor(hue / 60 degrees)
  localparam logic [SecW-1:0] SecRedYellow   = 4'd0;
  localparam logic [SecW-1:0] SecYellowGreen = 4'd1;
  localparam logic [SecW-1:0] SecGreenCyan   = 4'd2;
  localparam logic [SecW-1:0] SecCyanBlue    = 4'd3;
  localparam logic [SecW-1:0] SecBlueMagenta = 4'd4;

  typedef struct packed {
    logic [SecW-1:0] sector;
    logic [RemW-1:0] rem;
    logic [SatW-1:0] sat;
    logic [ValW-1:0] val;
  } sect_t;

  typedef struct packed {
    logic [VsW-1:0]  vs;
    logic [MagW-1:0] mag_r;
    logic [MagW-1:0] mag_g;
    logic [MagW-1:0] mag_b;
  } factor_t;

endpackage

FILE: hdl/hsv2rgb_sector.sv
module hsv2rgb_sector import hsv2rgb_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [HueW-1:0] hue_i,
  input  logic [SatW-1:0] saturation_i,
  input  logic [ValW-1:0] value_i,
  output sect_t           sect_o
);

  sect_t           sect_d, sect_q;
  logic [HueW-1:0] base;
  logic [HueW-1:0] diff;

  // Compare against every sector boundary in parallel, keep the highest hit
  always_comb begin
    sect_d.sector = '0;
    base          = '0;
    for (int k = 1; k < NumSector; k++) begin
      if (hue_i >= HueW'(k * HueSector)) begin
        sect_d.sector = SecW'(k);
        base          = HueW'(k * HueSector);
      end
    end
    diff        = hue_i - base;
    sect_d.rem  = diff[RemW-1:0];
    sect_d.sat  = saturation_i;
    sect_d.val  = value_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sect_q <= sect_d;
    end
  end

  assign sect_o = sect_q;

endmodule

FILE: hdl/hsv2rgb_factor.sv
module hsv2rgb_factor import hsv2rgb_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sect_t   sect_i,
  output factor_t fac_o
);

  localparam int unsigned NW = MagW + 3;

  factor_t               fac_d, fac_q;
  logic [RemW-1:0]       rem_c;
  logic [SatW+RemW-1:0]  prod_q;
  logic [SatW+RemW-1:0]  prod_t;
  logic [SatW+RemW-1:0]  prod_p;
  logic signed [NW-1:0]  n_v, n_p, n_q, n_t;
  logic [MagW-1:0]       m_v, m_p, m_q, m_t;

  // Drop nonpositive factors to zero; the channel then reads zero
  function automatic logic [MagW-1:0] pos_mag(input logic signed [NW-1:0] n);
    if (n <= 0) begin
      return '0;
    end
    return n[MagW-1:0];
  endfunction

  always_comb begin
    rem_c  = RemW'(HueSector) - sect_i.rem;
    prod_q = (SatW+RemW)'(sect_i.sat) * (SatW+RemW)'(sect_i.rem);
    prod_t = (SatW+RemW)'(sect_i.sat) * (SatW+RemW)'(rem_c);
    prod_p = (SatW+RemW)'(sect_i.sat) * (SatW+RemW)'(HueSector);
    n_v    = NW'(FracDen);
    n_p    = NW'(FracDen) - $signed({1'b0, prod_p});
    n_q    = NW'(FracDen) - $signed({1'b0, prod_q});
    n_t    = NW'(FracDen) - $signed({1'b0, prod_t});
    m_v    = pos_mag(n_v);
    m_p    = pos_mag(n_p);
    m_q    = pos_mag(n_q);
    m_t    = pos_mag(n_t);

    fac_d.vs = (VsW'(sect_i.val) << 8) - VsW'(sect_i.val);

    case (sect_i.sector)
      SecRedYellow: begin
        fac_d.mag_r = m_v; fac_d.mag_g = m_t; fac_d.mag_b = m_p;
      end
      SecYellowGreen: begin
        fac_d.mag_r = m_q; fac_d.mag_g = m_v; fac_d.mag_b = m_p;
      end
      SecGreenCyan: begin
        fac_d.mag_r = m_p; fac_d.mag_g = m_v; fac_d.mag_b = m_t;
      end
      SecCyanBlue: begin
        fac_d.mag_r = m_p; fac_d.mag_g = m_q; fac_d.mag_b = m_v;
      end
      SecBlueMagenta: begin
        fac_d.mag_r = m_t; fac_d.mag_g = m_p; fac_d.mag_b = m_v;
      end
      default: begin
        fac_d.mag_r = m_v; fac_d.mag_g = m_p; fac_d.mag_b = m_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fac_q <= fac_d;
    end
  end

  assign fac_o = fac_q;

endmodule

FILE: hdl/hsv2rgb_scale.sv
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             en_mul_i,
  input  logic             en_div_i,
  input  logic [VsW-1:0]   vs_i,
  input  logic [MagW-1:0]  mag_i,
  output logic [ByteW-1:0] byte_o
);

  // 2^16 / 15 rounded up; exact for all dividends below 4681
  localparam int unsigned RecipW = 13;
  localparam logic [RecipW-1:0] Recip15 = 13'd4370;
  localparam int unsigned Lim = (ChanMax + 1) * 15;

  logic [VsW+MagW-1:0]      prod;
  logic [HiW-1:0]           hi_d, hi_q;
  logic [RemW+RecipW-1:0]   quot;
  logic [ByteW-1:0]         byte_d, byte_q;

  // 255 * v * N / (2^28 * 15): drop the power of two here
  assign prod = (VsW+MagW)'(vs_i) * (VsW+MagW)'(mag_i);
  assign hi_d = prod[VsW+MagW-1:28];

  always_comb begin
    quot = (RemW+RecipW)'(hi_q[RemW-1:0]) * (RemW+RecipW)'(Recip15);
    if (hi_q >= HiW'(Lim)) begin
      byte_d = ByteW'(ChanMax);
    end else begin
      byte_d = quot[16 +: ByteW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      hi_q <= hi_d;
    end
    if (en_div_i) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: hdl/hsv_to_rgb_pixel_unit.sv
// HSV to RGB pixel converter, four register stages.
// Throughput: one pixel per cycle while not stalled; the 20x22 channel multiply feeds stage 3.
// A stall bubbles back stage by stage; empty stages keep taking pixels.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data holds no reset.
module hsv_to_rgb_pixel_unit import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [SatW-1:0]  saturation_i,
  input  logic [ValW-1:0]  value_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [ByteW-1:0] red_o,
  output logic [ByteW-1:0] green_o,
  output logic [ByteW-1:0] blue_o
);

  // Stage valid bits: 1 sector split, 2 factors, 3 products, 4 output bytes
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic en1, en2, en3, en4;

  sect_t   sect;
  factor_t fac;

  // A stage may load when it is empty or its content moves on this cycle
  assign rdy4 = !v4_q || !stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Load payload only when a real pixel arrives
  assign en1 = rdy1 && valid_i;
  assign en2 = rdy2 && v1_q;
  assign en3 = rdy3 && v2_q;
  assign en4 = rdy4 && v3_q;

  always_comb begin
    v1_d = rdy1 ? valid_i : v1_q;
    v2_d = rdy2 ? v1_q    : v2_q;
    v3_d = rdy3 ? v2_q    : v3_q;
    v4_d = rdy4 ? v3_q    : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // Stage 1: sector and remainder within the sector
  hsv2rgb_sector u_sector (
    .clk_i        (clk_i),
    .en_i         (en1),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .value_i      (value_i),
    .sect_o       (sect)
  );

  // Stage 2: p, q, t numerators, channel order by sector
  hsv2rgb_factor u_factor (
    .clk_i  (clk_i),
    .en_i   (en2),
    .sect_i (sect),
    .fac_o  (fac)
  );

  // Stages 3 and 4: scale by 255 * value, divide, clamp
  hsv2rgb_scale u_scale_r (
    .clk_i    (clk_i),
    .en_mul_i (en3),
    .en_div_i (en4),
    .vs_i     (fac.vs),
    .mag_i    (fac.mag_r),
    .byte_o   (red_o)
  );

  hsv2rgb_scale u_scale_g (
    .clk_i    (clk_i),
    .en_mul_i (en3),
    .en_div_i (en4),
    .vs_i     (fac.vs),
    .mag_i    (fac.mag_g),
    .byte_o   (green_o)
  );

  hsv2rgb_scale u_scale_b (
    .clk_i    (clk_i),
    .en_mul_i (en3),
    .en_div_i (en4),
    .vs_i     (fac.vs),
    .mag_i    (fac.mag_b),
    .byte_o   (blue_o)
  );

  assign stall_o = !rdy1;
  assign valid_o = v4_q;

  // Upstream only sees a stall when every stage is full and the sink stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && v4_q && stall_i))
    else $error("stall raised with a bubble in the pipe");

  // A held stage 3 never loses its pixel
  a_hold_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> v3_q)
    else $error("stage 3 pixel dropped while blocked");

  // A transfer into an empty pipe reaches the output after passing all four register stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !v1_q && !v2_q && !v3_q && !v4_q) |-> ##4 valid_o)
    else $error("pixel did not reach the output in four cycles");

  // Output register only refills from stage 3
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v4_q && !v3_q) |=> !v4_q)
    else $error("output valid without a source pixel");

endmodule
